// ===== rtl/animation_rle_row_decoder_macros.svh =====
// assertion helpers shared by the port checker
`ifndef ANIMATION_RLE_ROW_DECODER_MACROS_SVH
`define ANIMATION_RLE_ROW_DECODER_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define ARLD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("port check failed");

// next-cycle implication
`define ARLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("port check failed");

`endif

// ===== rtl/arld_pkg.sv =====
`timescale 1ns / 1ps
package arld_pkg;

   localparam int WORD_W  = 16;
   localparam int COUNT_W = 8;
   localparam int FIRST_W = 16;
   localparam int FPR_W   = 16;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_ZERO_VALID  = 3'd1,
      STATUS_ZERO_TOTAL  = 3'd2,
      STATUS_VALID_ABOVE = 3'd3,
      STATUS_OVERRUN     = 3'd4
   } status_type;

   // input register contents handed to the decode stage
   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] word;
   } in_beat_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]  sample_value;
      logic        [COUNT_W-1:0] repeat_count;
      logic        [FIRST_W-1:0] first_frame;
      logic                      row_done;
      status_type                status;
   } rsp_payload_type;

endpackage

// ===== rtl/arld_if.sv =====
`timescale 1ns / 1ps
interface arld_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] data_word;

   modport source (output valid, output data_word, input ready);
   modport sink   (input valid, input data_word, output ready);
endinterface

interface arld_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_value;
   logic        [7:0]  repeat_count;
   logic        [15:0] first_frame;
   logic               row_done;
   logic        [2:0]  status;

   modport source (output valid, output sample_value, output repeat_count,
                   output first_frame, output row_done, output status, input ready);
   modport sink   (input valid, input sample_value, input repeat_count,
                   input first_frame, input row_done, input status, output ready);
endinterface

interface arld_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] frames_per_row;

   modport source (output valid, output frames_per_row, input ready);
   modport sink   (input valid, input frames_per_row, output ready);
endinterface

// ===== rtl/arld_in_stage.sv =====
`timescale 1ns / 1ps
module arld_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   arld_req_if.sink             req,
   input  logic                 advance,
   output arld_pkg::in_beat_type beat
);
   import arld_pkg::*;

   logic              valid_ff, valid_in;
   logic [WORD_W-1:0] word_ff, word_in;

   always_comb begin
      req.ready = !valid_ff || advance;
      valid_in  = valid_ff;
      word_in   = word_ff;
      if (req.ready) begin
         valid_in = req.valid;
         word_in  = req.data_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign beat.valid = valid_ff;
   assign beat.word  = word_ff;

endmodule

// ===== rtl/arld_decode.sv =====
`timescale 1ns / 1ps
module arld_decode #(
   parameter int FRAME_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  arld_pkg::in_beat_type beat,
   output logic                 advance,
   arld_rsp_if.source           rsp,
   arld_csr_if.sink             csr
);
   import arld_pkg::*;

   localparam int FW = FRAME_BITS + 1;
   localparam int CW = (FW > FPR_W) ? FW : FPR_W;
   localparam int SW = CW + 1;

   logic               expecting_meta_ff, expecting_meta_in;
   logic [COUNT_W-1:0] valid_left_ff, valid_left_in;
   logic [COUNT_W-1:0] pad_frames_ff, pad_frames_in;
   logic [FW-1:0]      frames_done_ff, frames_done_in;
   logic               run_overruns_ff, run_overruns_in;
   logic [FPR_W-1:0]   frames_per_row_ff, frames_per_row_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    payload_ff, payload_in;

   logic [COUNT_W-1:0] meta_valid, meta_total, repeat_n;
   logic [FW-1:0]      frames_sum;
   logic               take;
   status_type         meta_status;

   assign csr.ready = 1'b1;
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign take      = beat.valid && advance;

   always_comb begin
      meta_valid = beat.word[COUNT_W-1:0];
      meta_total = beat.word[WORD_W-1:COUNT_W];
      if (meta_valid == '0) begin
         meta_status = STATUS_ZERO_VALID;
      end else if (meta_total == '0) begin
         meta_status = STATUS_ZERO_TOTAL;
      end else if (meta_total < meta_valid) begin
         meta_status = STATUS_VALID_ABOVE;
      end else begin
         meta_status = STATUS_OK;
      end

      // the last sample of a run also stands for the padding frames
      repeat_n   = (valid_left_ff <= COUNT_W'(1)) ? pad_frames_ff + COUNT_W'(1)
                                                  : COUNT_W'(1);
      frames_sum = frames_done_ff + FW'(repeat_n);

      expecting_meta_in = expecting_meta_ff;
      valid_left_in     = valid_left_ff;
      pad_frames_in     = pad_frames_ff;
      frames_done_in    = frames_done_ff;
      run_overruns_in   = run_overruns_ff;
      frames_per_row_in = frames_per_row_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp.ready;
      payload_in        = payload_ff;

      if (csr.valid) begin
         frames_per_row_in = csr.frames_per_row;
      end

      if (take) begin
         if (expecting_meta_ff) begin
            if (meta_status != STATUS_OK) begin
               rsp_valid_in            = 1'b1;
               payload_in.sample_value = '0;
               payload_in.repeat_count = '0;
               payload_in.first_frame  = FIRST_W'(frames_done_ff);
               payload_in.row_done     = 1'b1;
               payload_in.status       = meta_status;
               frames_done_in          = '0;
               valid_left_in           = '0;
               pad_frames_in           = '0;
               run_overruns_in         = 1'b0;
            end else begin
               valid_left_in     = meta_valid;
               pad_frames_in     = meta_total - meta_valid;
               run_overruns_in   = (SW'(frames_done_ff) + SW'(meta_total))
                                   > SW'(frames_per_row_ff);
               expecting_meta_in = 1'b0;
            end
         end else begin
            rsp_valid_in            = 1'b1;
            payload_in.sample_value = beat.word;
            payload_in.repeat_count = repeat_n;
            payload_in.first_frame  = FIRST_W'(frames_done_ff);
            payload_in.row_done     = 1'b0;
            payload_in.status       = STATUS_OK;
            frames_done_in          = frames_sum;
            valid_left_in           = valid_left_ff - COUNT_W'(1);
            if (valid_left_ff == COUNT_W'(1)) begin
               expecting_meta_in = 1'b1;
               pad_frames_in     = '0;
               run_overruns_in   = 1'b0;
               if (run_overruns_ff) begin
                  payload_in.row_done = 1'b1;
                  payload_in.status   = STATUS_OVERRUN;
                  frames_done_in      = '0;
               end else if (CW'(frames_sum) == CW'(frames_per_row_ff)) begin
                  payload_in.row_done = 1'b1;
                  frames_done_in      = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expecting_meta_ff <= 1'b1;
         valid_left_ff     <= '0;
         pad_frames_ff     <= '0;
         frames_done_ff    <= '0;
         run_overruns_ff   <= 1'b0;
         frames_per_row_ff <= FPR_W'(1);
         rsp_valid_ff      <= 1'b0;
      end else begin
         expecting_meta_ff <= expecting_meta_in;
         valid_left_ff     <= valid_left_in;
         pad_frames_ff     <= pad_frames_in;
         frames_done_ff    <= frames_done_in;
         run_overruns_ff   <= run_overruns_in;
         frames_per_row_ff <= frames_per_row_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      payload_ff <= payload_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sample_value = payload_ff.sample_value;
   assign rsp.repeat_count = payload_ff.repeat_count;
   assign rsp.first_frame  = payload_ff.first_frame;
   assign rsp.row_done     = payload_ff.row_done;
   assign rsp.status       = payload_ff.status;

endmodule

// ===== rtl/animation_rle_row_decoder.sv =====
`timescale 1ns / 1ps
// channel  dir  payload                                               beat when
// req      in   data_word                                             valid && ready
// rsp      out  sample_value repeat_count first_frame row_done status valid && ready
// csr      in   frames_per_row                                        valid && ready
//
// one word accepted per cycle while rsp is not stalled; a sample result passes from its
// beat through the input register, then decode logic into the result register
// meta words that pass the checks give no result
// reset clears the run state, the result valid and sets frames_per_row to 1
// a stalled rsp holds its beat; req ready then drops once the input register is full
module animation_rle_row_decoder #(
   parameter int FRAME_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   arld_req_if.sink   req,
   arld_rsp_if.source rsp,
   arld_csr_if.sink   csr
);
   import arld_pkg::*;

   in_beat_type beat;
   logic        advance;

   arld_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .advance (advance),
      .beat    (beat)
   );

   arld_decode #(
      .FRAME_BITS (FRAME_BITS)
   ) u_decode (
      .clock   (clock),
      .reset   (reset),
      .beat    (beat),
      .advance (advance),
      .rsp     (rsp),
      .csr     (csr)
   );

endmodule

// ===== rtl/arld_port_checker.sv =====
`timescale 1ns / 1ps
`include "animation_rle_row_decoder_macros.svh"
module arld_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_sample_value,
   input logic [7:0]  rsp_repeat_count,
   input logic [15:0] rsp_first_frame,
   input logic        rsp_row_done,
   input logic [2:0]  rsp_status
);
   import arld_pkg::*;

   logic meta_error;

   assign meta_error = (rsp_status == STATUS_ZERO_VALID) || (rsp_status == STATUS_ZERO_TOTAL)
                       || (rsp_status == STATUS_VALID_ABOVE);

   `ARLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_sample_value, rsp_repeat_count, rsp_first_frame, rsp_row_done, rsp_status}))
   `ARLD_ASSERT_NOW(a_error_ends_row, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_row_done)
   `ARLD_ASSERT_NOW(a_meta_error_empty, clock, reset, rsp_valid && meta_error, rsp_repeat_count == 8'd0 && rsp_sample_value == 16'd0)
   `ARLD_ASSERT_NOW(a_sample_covers_frame, clock, reset, rsp_valid && !meta_error, rsp_repeat_count != 8'd0)

endmodule

bind animation_rle_row_decoder arld_port_checker u_port_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_sample_value (rsp.sample_value),
   .rsp_repeat_count (rsp.repeat_count),
   .rsp_first_frame  (rsp.first_frame),
   .rsp_row_done     (rsp.row_done),
   .rsp_status       (rsp.status)
);
